/* hw/rtl/srfp_pkg.sv */
// ----------------------------------------------------------------------------
// srfp_pkg
// Shared types, constants and helpers for the three-phase SRF PLL / SPWM unit.
// ----------------------------------------------------------------------------
package srfp_pkg;

    // cosine table and angle geometry
    localparam int TRIG_DEPTH = 1024;
    localparam int TRIG_AW    = $clog2(TRIG_DEPTH);
    localparam int ANGLE_BITS = 32;

    typedef logic [ANGLE_BITS-1:0] angle_t;

    localparam logic [63:0] TURN_W       = 64'd1 << ANGLE_BITS;
    localparam logic [63:0] HALF_TURN_W  = TURN_W >> 1;
    localparam logic [63:0] SIN_OFF_W    = 64'd3 * ((TURN_W + 64'd3) / 64'd4);
    localparam logic [63:0] SIXTH_W      = (TURN_W + 64'd5) / 64'd6;
    localparam logic [63:0] FIVE_SIXTH_W = 64'd5 * SIXTH_W;

    localparam angle_t HALF_TURN  = HALF_TURN_W[ANGLE_BITS-1:0];
    localparam angle_t SIN_OFF    = SIN_OFF_W[ANGLE_BITS-1:0];
    localparam angle_t SIXTH      = SIXTH_W[ANGLE_BITS-1:0];
    localparam angle_t FIVE_SIXTH = FIVE_SIXTH_W[ANGLE_BITS-1:0];

    // clarke coefficients, Q0.16, and pi/2 in Q2.30
    localparam logic [15:0] THIRD_Q16     = 16'd21845;
    localparam logic [15:0] INV_SQRT3_Q16 = 16'd37837;
    localparam logic [63:0] PI_HALF_Q30   = 64'd1686629713;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_ADC_OFFSET   = 3'd0,
        CFG_ADC_GAIN     = 3'd1,
        CFG_PI_GAIN_NOW  = 3'd2,
        CFG_PI_GAIN_PREV = 3'd3,
        CFG_NOMINAL_STEP = 3'd4,
        CFG_MOD_INDEX    = 3'd5,
        CFG_HALF_PERIOD  = 3'd6
    } cfg_idx_t;

    // sequencer states
    typedef enum logic [4:0] {
        ST_IDLE, ST_VA, ST_VB, ST_VC, ST_VW, ST_AL, ST_BE, ST_D1, ST_D2,
        ST_Q1, ST_Q2, ST_PI1, ST_PI2, ST_DEV0, ST_DEV1, ST_ANG,
        ST_RA, ST_RB, ST_RC, ST_MB, ST_MB2, ST_MC, ST_MC2, ST_FIN, ST_OUT
    } state_t;

    typedef logic [15:0] cos_rom_t [TRIG_DEPTH];

    // quarter-wave cosine table, Q1.15, built at elaboration
    function automatic cos_rom_t build_cos_rom();
        cos_rom_t    rom;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic signed [63:0] sum;
        logic signed [63:0] e;
        for (int i = 0; i < TRIG_DEPTH; i++) begin
            x    = (PI_HALF_Q30 * 64'(i)) / 64'(TRIG_DEPTH);
            x2   = (x * x) >> 30;
            term = 64'd1 << 30;
            sum  = $signed(term);
            for (int n = 1; n <= 12; n++) begin
                term = ((term * x2) >> 30) / 64'((2 * n - 1) * (2 * n));
                if (n % 2 == 1) sum = sum - $signed(term);
                else            sum = sum + $signed(term);
            end
            if (sum < 0) sum = 64'sd0;
            if (sum > (64'sd1 <<< 30)) sum = 64'sd1 <<< 30;
            e = (sum + 64'sd16384) >>> 15;
            rom[i] = (e > 64'sd32767) ? 16'd32767 : e[15:0];
        end
        return rom;
    endfunction

    // saturate to 24 bits signed
    function automatic logic signed [23:0] sat24(input logic signed [63:0] v);
        if (v > 64'sd8388607)        return 24'sh7FFFFF;
        else if (v < -64'sd8388608)  return 24'sh800000;
        else                         return v[23:0];
    endfunction

    // saturate to 40 bits signed
    function automatic logic signed [39:0] sat40(input logic signed [63:0] v);
        if (v > 64'sd549755813887)        return 40'sh7FFFFFFFFF;
        else if (v < -64'sd549755813888)  return 40'sh8000000000;
        else                              return v[39:0];
    endfunction

    // compare value from product m*cos*h: clamp((h*2^31 + p) >> 31, 0, 2h)
    function automatic logic [15:0] leg_cmp(input logic signed [63:0] p,
                                            input logic [14:0] h);
        logic signed [63:0] num;
        logic [32:0]        c;
        logic [15:0]        twoh;
        num  = $signed({18'd0, h, 31'd0}) + p;
        c    = num[63:31];
        twoh = {h, 1'b0};
        if (num < 0)                return 16'd0;
        else if (c > 33'(twoh))     return twoh;
        else                        return c[15:0];
    endfunction

endpackage

/* hw/rtl/srfp_cos_rom.sv */
// ----------------------------------------------------------------------------
// srfp_cos_rom
// Full-turn cosine from a quarter-wave table, registered read.
// ----------------------------------------------------------------------------
module srfp_cos_rom (
    input  logic                  aclk,
    input  srfp_pkg::angle_t      angle,
    output logic signed [15:0]    cos_q
);
    import srfp_pkg::*;

    localparam cos_rom_t ROM = build_cos_rom();

    logic [TRIG_AW+1:0] pos;
    logic [1:0]         quad;
    logic [TRIG_AW-1:0] r;
    logic [TRIG_AW:0]   j;
    logic               neg;
    logic [15:0]        val;

    // quadrant fold
    always_comb begin
        pos  = angle[ANGLE_BITS-1 -: TRIG_AW+2];
        quad = pos[TRIG_AW+1:TRIG_AW];
        r    = pos[TRIG_AW-1:0];
        j    = quad[0] ? ((TRIG_AW+1)'(TRIG_DEPTH) - {1'b0, r}) : {1'b0, r};
        neg  = quad[1] ^ quad[0];
        val  = j[TRIG_AW] ? 16'd0 : ROM[j[TRIG_AW-1:0]];
    end

    // registered table read
    always_ff @(posedge aclk) begin
        cos_q <= neg ? -$signed(val) : $signed(val);
    end

endmodule

/* hw/rtl/srfp_mul.sv */
// ----------------------------------------------------------------------------
// srfp_mul
// Shared signed 33x33 multiplier with registered product.
// ----------------------------------------------------------------------------
module srfp_mul (
    input  logic                aclk,
    input  logic signed [32:0]  op_a,
    input  logic signed [32:0]  op_b,
    output logic signed [63:0]  prod
);
    logic signed [65:0] full;

    // product register
    assign full = op_a * op_b;
    always_ff @(posedge aclk) begin
        prod <= full[63:0];
    end

endmodule

/* hw/rtl/three_phase_srf_pll_spwm_unit.sv */
// ----------------------------------------------------------------------------
// three_phase_srf_pll_spwm_unit
// Sample in, a 24-step sequence of shared-multiplier work, one result word out.
// One word at a time, set by the single shared multiplier and the cosine
// table port that the sequencer steps through; a stalled result word holds
// the sequencer in its last step.
// Reset: synchronous active-low aresetn clears PLL state and control, and
// loads the configuration registers with their defaults.
// ----------------------------------------------------------------------------
module three_phase_srf_pll_spwm_unit (
    input  logic         aclk,
    input  logic         aresetn,
    // config write port
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_wdata,
    // input word
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [39:0]  s_tdata,   // phase_a_code, phase_b_code, phase_c_code
    // result word
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata    // compare_a, compare_b, compare_c,
                                    // d_voltage, q_voltage, grid_angle
);
    import srfp_pkg::*;

    // configuration registers
    logic [11:0]        adc_offset_reg;
    logic [15:0]        adc_gain_reg;
    logic signed [31:0] pi_now_reg, pi_prev_reg;
    logic [31:0]        nominal_reg;
    logic [16:0]        mod_index_reg;
    logic [14:0]        half_period_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            adc_offset_reg  <= 12'd2048;
            adc_gain_reg    <= 16'd14314;
            pi_now_reg      <= '0;
            pi_prev_reg     <= '0;
            nominal_reg     <= 32'd42949673;
            mod_index_reg   <= 17'd32768;
            half_period_reg <= 15'd7500;
        end else if (cfg_we) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_ADC_OFFSET:   adc_offset_reg  <= cfg_wdata[11:0];
                CFG_ADC_GAIN:     adc_gain_reg    <= cfg_wdata[15:0];
                CFG_PI_GAIN_NOW:  pi_now_reg      <= $signed(cfg_wdata);
                CFG_PI_GAIN_PREV: pi_prev_reg     <= $signed(cfg_wdata);
                CFG_NOMINAL_STEP: nominal_reg     <= cfg_wdata;
                CFG_MOD_INDEX:    mod_index_reg   <= cfg_wdata[16:0];
                CFG_HALF_PERIOD:  half_period_reg <= cfg_wdata[14:0];
                default: ;
            endcase
        end
    end

    // sequencer and datapath registers
    state_t state_reg, state_next;

    logic [11:0]        code_a_reg, code_b_reg, code_c_reg;
    logic signed [20:0] va_reg, vb_reg, vc_reg;
    logic signed [21:0] alpha_reg, beta_reg;
    logic signed [15:0] c_reg, s_reg, cb_reg, cc_reg;
    logic signed [63:0] acc_reg;
    logic signed [23:0] d_reg, q_reg;
    logic signed [39:0] dev_reg;
    logic [15:0]        cmp_a_reg, cmp_b_reg, cmp_c_reg;

    // pll state
    angle_t             angle_reg;
    logic signed [23:0] prev_q_reg;
    logic signed [39:0] fd_reg;

    // output register
    logic               m_valid_reg;
    logic [127:0]       m_data_reg;

    // shared units
    logic signed [32:0] mul_a, mul_b;
    logic signed [63:0] prod;
    angle_t             rom_angle;
    logic signed [15:0] rom_cos;

    srfp_mul u_mul (
        .aclk (aclk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    srfp_cos_rom u_rom (
        .aclk  (aclk),
        .angle (rom_angle),
        .cos_q (rom_cos)
    );

    logic               in_fire;
    logic signed [12:0] diff_a, diff_b, diff_c;
    logic signed [22:0] clarke_a;
    logic signed [21:0] clarke_b;
    logic signed [40:0] dev_sum;

    assign in_fire = s_tvalid && s_tready;
    assign diff_a  = $signed({1'b0, code_a_reg}) - $signed({1'b0, adc_offset_reg});
    assign diff_b  = $signed({1'b0, code_b_reg}) - $signed({1'b0, adc_offset_reg});
    assign diff_c  = $signed({1'b0, code_c_reg}) - $signed({1'b0, adc_offset_reg});
    assign clarke_a = 23'(va_reg) + 23'(va_reg) - 23'(vb_reg) - 23'(vc_reg);
    assign clarke_b = 22'(vb_reg) - 22'(vc_reg);
    assign dev_sum  = 41'(dev_reg) + 41'(fd_reg);

    // next state, multiplier operands and table address
    always_comb begin
        state_next = state_reg;
        mul_a      = '0;
        mul_b      = '0;
        rom_angle  = angle_reg;
        unique case (state_reg)
            ST_IDLE: if (in_fire) state_next = ST_VA;
            ST_VA: begin
                mul_a = 33'(diff_a);
                mul_b = $signed({17'd0, adc_gain_reg});
                state_next = ST_VB;
            end
            ST_VB: begin
                mul_a = 33'(diff_b);
                mul_b = $signed({17'd0, adc_gain_reg});
                rom_angle = angle_reg + SIN_OFF;
                state_next = ST_VC;
            end
            ST_VC: begin
                mul_a = 33'(diff_c);
                mul_b = $signed({17'd0, adc_gain_reg});
                state_next = ST_VW;
            end
            ST_VW: state_next = ST_AL;
            ST_AL: begin
                mul_a = 33'(clarke_a);
                mul_b = $signed({17'd0, THIRD_Q16});
                state_next = ST_BE;
            end
            ST_BE: begin
                mul_a = 33'(clarke_b);
                mul_b = $signed({17'd0, INV_SQRT3_Q16});
                state_next = ST_D1;
            end
            ST_D1: begin
                mul_a = 33'(c_reg);
                mul_b = 33'(alpha_reg);
                state_next = ST_D2;
            end
            ST_D2: begin
                mul_a = 33'(s_reg);
                mul_b = 33'(beta_reg);
                state_next = ST_Q1;
            end
            ST_Q1: begin
                mul_a = 33'(c_reg);
                mul_b = 33'(beta_reg);
                state_next = ST_Q2;
            end
            ST_Q2: begin
                mul_a = 33'(s_reg);
                mul_b = 33'(alpha_reg);
                state_next = ST_PI1;
            end
            ST_PI1: begin
                mul_a = 33'(pi_prev_reg);
                mul_b = 33'(prev_q_reg);
                state_next = ST_PI2;
            end
            ST_PI2: begin
                mul_a = 33'(pi_now_reg);
                mul_b = 33'(q_reg);
                state_next = ST_DEV0;
            end
            ST_DEV0: state_next = ST_DEV1;
            ST_DEV1: state_next = ST_ANG;
            ST_ANG:  state_next = ST_RA;
            ST_RA: begin
                rom_angle = angle_reg + HALF_TURN;
                state_next = ST_RB;
            end
            ST_RB: begin
                mul_a = $signed({16'd0, mod_index_reg});
                mul_b = 33'(rom_cos);
                rom_angle = angle_reg + SIXTH;
                state_next = ST_RC;
            end
            ST_RC: begin
                mul_a = prod[32:0];
                mul_b = $signed({18'd0, half_period_reg});
                rom_angle = angle_reg + FIVE_SIXTH;
                state_next = ST_MB;
            end
            ST_MB: begin
                mul_a = $signed({16'd0, mod_index_reg});
                mul_b = 33'(cb_reg);
                state_next = ST_MB2;
            end
            ST_MB2: begin
                mul_a = prod[32:0];
                mul_b = $signed({18'd0, half_period_reg});
                state_next = ST_MC;
            end
            ST_MC: begin
                mul_a = $signed({16'd0, mod_index_reg});
                mul_b = 33'(cc_reg);
                state_next = ST_MC2;
            end
            ST_MC2: begin
                mul_a = prod[32:0];
                mul_b = $signed({18'd0, half_period_reg});
                state_next = ST_FIN;
            end
            ST_FIN: state_next = ST_OUT;
            ST_OUT: if (!m_valid_reg || m_tready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // state register and pll state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            angle_reg   <= '0;
            prev_q_reg  <= '0;
            fd_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_ANG) begin
                angle_reg  <= angle_reg + nominal_reg[ANGLE_BITS-1:0]
                            + dev_sum[ANGLE_BITS:1];
                fd_reg     <= dev_reg;
                prev_q_reg <= q_reg;
            end
            if (state_reg == ST_OUT && (!m_valid_reg || m_tready))
                m_valid_reg <= 1'b1;
            else if (m_tready)
                m_valid_reg <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                code_a_reg <= s_tdata[11:0];
                code_b_reg <= s_tdata[23:12];
                code_c_reg <= s_tdata[35:24];
            end
            ST_VB: begin
                va_reg <= 21'(prod >>> 8);
                c_reg  <= rom_cos;
            end
            ST_VC: begin
                vb_reg <= 21'(prod >>> 8);
                s_reg  <= rom_cos;
            end
            ST_VW:   vc_reg    <= 21'(prod >>> 8);
            ST_BE:   alpha_reg <= 22'(prod >>> 16);
            ST_D1:   beta_reg  <= 22'(prod >>> 16);
            ST_D2:   acc_reg   <= prod;
            ST_Q1:   d_reg     <= sat24((acc_reg + prod) >>> 15);
            ST_Q2:   acc_reg   <= prod;
            ST_PI1:  q_reg     <= sat24((acc_reg - prod) >>> 15);
            ST_PI2:  acc_reg   <= prod;
            ST_DEV0: acc_reg   <= acc_reg + prod;
            ST_DEV1: dev_reg   <= sat40(64'(fd_reg) + (acc_reg >>> 24));
            ST_RC:   cb_reg    <= rom_cos;
            ST_MB: begin
                cc_reg    <= rom_cos;
                cmp_a_reg <= leg_cmp(prod, half_period_reg);
            end
            ST_MC:   cmp_b_reg <= leg_cmp(prod, half_period_reg);
            ST_FIN:  cmp_c_reg <= leg_cmp(prod, half_period_reg);
            ST_OUT: begin
                if (!m_valid_reg || m_tready)
                    m_data_reg <= {32'(angle_reg), q_reg, d_reg,
                                   cmp_c_reg, cmp_b_reg, cmp_a_reg};
            end
            default: ;
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

/* hw/rtl/srfp_checker.sv */
// ----------------------------------------------------------------------------
// srfp_checker
// Port-level checks for the SRF PLL / SPWM unit, bound to the top level.
// ----------------------------------------------------------------------------
module srfp_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [127:0] m_tdata
);
    // reset leaves the block idle and empty
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> s_tready && !m_tvalid)
        else $error("not idle after reset");

    // one word at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("accepted while busy");

    // a result never appears in the cycle right after an accept
    a_no_early_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !$rose(m_tvalid))
        else $error("result too early");

    // stalled result word holds
    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled word changed");

endmodule

bind three_phase_srf_pll_spwm_unit srfp_checker u_srfp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the three-phase SRF PLL / SPWM unit. Sample words go
// in through the input stream. A bit-accurate predictor computes the d/q
// voltages, the angle and the three compare values for each accepted word.
// Every result word is checked against that prediction. The run covers
// several register settings, the extremes among them, and several idle and
// stall mixes on the two streams.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import srfp_pkg::*;

    localparam logic [2:0] CFG_UNUSED = 3'd7;
    localparam int         LIMIT_CYCLES = 600000;
    localparam int         SETTLE_CYCLES = 40;

    typedef struct {
        logic [15:0]        cmp_a;
        logic [15:0]        cmp_b;
        logic [15:0]        cmp_c;
        logic signed [23:0] d_v;
        logic signed [23:0] q_v;
        logic [31:0]        ang;
    } pll_out_t;

    typedef struct {
        int                 a;
        int                 b;
        int                 c;
        bit                 typed;
        logic signed [23:0] d_v;
        logic signed [23:0] q_v;
        logic [31:0]        ang;
    } sample_row_t;

    logic         aclk;
    logic         aresetn;
    logic         cfg_we;
    logic [2:0]   cfg_index;
    logic [31:0]  cfg_wdata;
    logic         s_tvalid;
    logic         s_tready;
    logic [39:0]  s_tdata;   // phase_a_code, phase_b_code, phase_c_code
    logic         m_tvalid;
    logic         m_tready;
    logic [127:0] m_tdata;   // compare_a, compare_b, compare_c, d_voltage,
                             // q_voltage, grid_angle

    three_phase_srf_pll_spwm_unit u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // predictor state and register copies
    int unsigned        cos_q15 [1024];
    longint             offset_r, gain_r, gn_r, gp_r, mod_r, hp_r;
    logic [31:0]        step_r;
    logic [31:0]        pll_ang;
    longint             q_prev, dev_now;
    pll_out_t           pending_results [$];
    int                 errors;
    int                 idle_pct;
    int                 stall_pct;
    longint             cycles;

    // quarter-wave cosine, Taylor series in Q2.30 rounded to Q1.15
    function automatic void fill_cos_table();
        longint unsigned x, x2, term;
        longint          acc, rnd;
        for (int i = 0; i < 1024; i++) begin
            x    = (64'd1686629713 * longint'(i)) / 1024;
            x2   = (x * x) >> 30;
            term = 64'd1 << 30;
            acc  = longint'(term);
            for (int n = 1; n <= 12; n++) begin
                term = ((term * x2) >> 30) / longint'((2 * n - 1) * (2 * n));
                acc  = (n % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
            end
            if (acc < 0) acc = 0;
            if (acc > (64'sd1 <<< 30)) acc = 64'sd1 <<< 30;
            rnd = (acc + 16384) >>> 15;
            cos_q15[i] = (rnd > 32767) ? 32767 : int'(rnd);
        end
    endfunction

    function automatic longint quarter_entry(int j);
        return (j >= 1024) ? 0 : longint'(cos_q15[j]);
    endfunction

    function automatic longint turn_cosine(logic [31:0] a);
        int r;
        r = int'(a[29:20]);
        case (a[31:30])
            2'd0: return quarter_entry(r);
            2'd1: return -quarter_entry(1024 - r);
            2'd2: return -quarter_entry(r);
            default: return quarter_entry(1024 - r);
        endcase
    endfunction

    function automatic logic [15:0] pwm_compare(logic [31:0] a);
        longint num, c;
        num = hp_r * 64'sd2147483648 + mod_r * turn_cosine(a) * hp_r;
        if (num < 0) return 16'd0;
        c = num >>> 31;
        return (c > 2 * hp_r) ? 16'(2 * hp_r) : 16'(c);
    endfunction

    function automatic longint clip(longint v, int bits);
        longint hi;
        hi = (64'sd1 <<< (bits - 1)) - 1;
        return (v > hi) ? hi : ((v < -hi - 1) ? -hi - 1 : v);
    endfunction

    // one PLL step: ADC scaling, clarke, park, PI, angle update, SPWM legs
    function automatic pll_out_t pll_step(int a, int b, int c);
        pll_out_t r;
        longint   va, vb, vc, al, be, cs, sn, dv, qv, dev, half;
        logic [31:0] na;
        va = ((longint'(a) - offset_r) * gain_r) >>> 8;
        vb = ((longint'(b) - offset_r) * gain_r) >>> 8;
        vc = ((longint'(c) - offset_r) * gain_r) >>> 8;
        al = ((2 * va - vb - vc) * 21845) >>> 16;
        be = ((vb - vc) * 37837) >>> 16;
        cs = turn_cosine(pll_ang);
        sn = turn_cosine(pll_ang + 32'hC000_0000);
        dv = clip((cs * al + sn * be) >>> 15, 24);
        qv = clip((cs * be - sn * al) >>> 15, 24);
        dev  = clip(dev_now + ((gn_r * qv + gp_r * q_prev) >>> 24), 40);
        half = (dev + dev_now) >>> 1;
        na   = 32'(longint'(pll_ang) + longint'(step_r) + half);
        dev_now = dev;
        q_prev  = qv;
        pll_ang = na;
        r.cmp_a = pwm_compare(na + 32'h8000_0000);
        r.cmp_b = pwm_compare(na + 32'd715827883);
        r.cmp_c = pwm_compare(na + 32'd3579139415);
        r.d_v   = 24'(dv);
        r.q_v   = 24'(qv);
        r.ang   = na;
        return r;
    endfunction

    // register write, mirrored into the predictor; caller drops cfg_we
    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            CFG_ADC_OFFSET:   offset_r = longint'(val[11:0]);
            CFG_ADC_GAIN:     gain_r   = longint'(val[15:0]);
            CFG_PI_GAIN_NOW:  gn_r     = longint'($signed(val));
            CFG_PI_GAIN_PREV: gp_r     = longint'($signed(val));
            CFG_NOMINAL_STEP: step_r   = val;
            CFG_MOD_INDEX:    mod_r    = longint'(val[16:0]);
            CFG_HALF_PERIOD:  hp_r     = longint'(val[14:0]);
            default: ;
        endcase
    endtask

    // push one sample word; expectation queued at the accepting edge
    task automatic send_sample(int a, int b, int c, bit typed = 0,
                               logic signed [23:0] d_t = 0,
                               logic signed [23:0] q_t = 0,
                               logic [31:0] ang_t = 0);
        pll_out_t r;
        if ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'd0, 12'(c), 12'(b), 12'(a)};
        do @(posedge aclk); while (!s_tready);
        r = pll_step(a, b, c);
        if (typed) begin
            r.d_v = d_t;
            r.q_v = q_t;
            r.ang = ang_t;
        end
        pending_results.push_back(r);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [31:0] pick(logic [31:0] lo, logic [31:0] hi,
                                         logic [31:0] mid);
        case ($urandom_range(3))
            0: return lo;
            1: return hi;
            default: return mid;
        endcase
    endfunction

    // fresh register setting; extremes come up often
    task automatic new_setting(int ph);
        logic [31:0] g;
        write_reg(CFG_ADC_OFFSET, pick(0, 4095, $urandom_range(1900, 2200)));
        write_reg(CFG_ADC_GAIN, pick(0, 65535, $urandom_range(65535)));
        g = (ph % 3 == 2) ? pick(32'h8000_0000, 32'h7FFF_FFFF, $urandom)
                          : $urandom_range(1 << 22);
        write_reg(CFG_PI_GAIN_NOW, g);
        write_reg(CFG_PI_GAIN_PREV, (ph % 3 == 2) ? ~g : -(g - (g >> 4)));
        write_reg(CFG_NOMINAL_STEP, pick(0, 32'hFFFF_FFFF, $urandom));
        write_reg(CFG_MOD_INDEX, pick(0, 65536, $urandom_range(32'h1FFFF)));
        write_reg(CFG_HALF_PERIOD, pick(0, 32767, $urandom_range(1, 32767)));
        write_reg(CFG_UNUSED, $urandom);
        cfg_we <= 1'b0;
    endtask

    sample_row_t directed [12] = '{
        '{2048, 2048, 2048, 1, 0, 0, 32'd42949673},
        '{0,    0,    0,    1, 0, 0, 32'd85899346},
        '{4095, 4095, 4095, 1, 0, 0, 32'd128849019},
        '{4095, 0,    0,    0, 0, 0, 0},
        '{0,    4095, 0,    0, 0, 0, 0},
        '{0,    0,    4095, 0, 0, 0, 0},
        '{4095, 0,    4095, 0, 0, 0, 0},
        '{2048, 4095, 0,    0, 0, 0, 0},
        '{1,    2,    4094, 0, 0, 0, 0},
        '{2730, 1365, 2048, 0, 0, 0, 0},
        '{4095, 4095, 0,    0, 0, 0, 0},
        '{0,    4095, 4095, 0, 0, 0, 0}
    };

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // receiver stalls
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // result checker
    always @(posedge aclk) begin
        pll_out_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("result word with nothing expected: %h", m_tdata);
                errors++;
            end else begin
                e = pending_results.pop_front();
                if (m_tdata[15:0] !== e.cmp_a) begin
                    $error("compare_a exp %0d got %0d", e.cmp_a, m_tdata[15:0]);
                    errors++;
                end
                if (m_tdata[31:16] !== e.cmp_b) begin
                    $error("compare_b exp %0d got %0d", e.cmp_b, m_tdata[31:16]);
                    errors++;
                end
                if (m_tdata[47:32] !== e.cmp_c) begin
                    $error("compare_c exp %0d got %0d", e.cmp_c, m_tdata[47:32]);
                    errors++;
                end
                if (m_tdata[71:48] !== e.d_v) begin
                    $error("d_voltage exp %0d got %0d", e.d_v, $signed(m_tdata[71:48]));
                    errors++;
                end
                if (m_tdata[95:72] !== e.q_v) begin
                    $error("q_voltage exp %0d got %0d", e.q_v, $signed(m_tdata[95:72]));
                    errors++;
                end
                if (m_tdata[127:96] !== e.ang) begin
                    $error("grid_angle exp %0d got %0d", e.ang, m_tdata[127:96]);
                    errors++;
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("three_phase_srf_pll_spwm_unit regression: fail");
            $finish;
        end
    end

    // stimulus
    initial begin
        real th, amp, w;
        int  code [3];
        errors    = 0;
        idle_pct  = 0;
        stall_pct = 0;
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = 3'd0;
        cfg_wdata = 32'd0;
        s_tvalid  = 1'b0;
        s_tdata   = 40'd0;
        m_tready  = 1'b0;
        fill_cos_table();
        offset_r = 2048; gain_r = 14314; gn_r = 0; gp_r = 0;
        step_r = 32'd42949673; mod_r = 32768; hp_r = 7500;
        pll_ang = 0; q_prev = 0; dev_now = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed words at reset defaults
        foreach (directed[i])
            send_sample(directed[i].a, directed[i].b, directed[i].c, directed[i].typed,
                        directed[i].d_v, directed[i].q_v, directed[i].ang);
        drain();

        // random phases: mostly clean three-phase sine sets, some noise
        th = 0.0;
        for (int ph = 0; ph < 8; ph++) begin
            new_setting(ph);
            idle_pct  = (ph % 4 == 1 || ph % 4 == 3) ? ((ph % 4 == 1) ? 69 : 26) : 0;
            stall_pct = (ph % 4 == 2 || ph % 4 == 3) ? ((ph % 4 == 2) ? 69 : 26) : 0;
            amp = real'($urandom_range(2047));
            w   = real'($urandom_range(1, 400)) / 1000.0;
            for (int n = 0; n < 150; n++) begin
                if ($urandom_range(99) < 75) begin
                    th += w;
                    for (int k = 0; k < 3; k++) begin
                        code[k] = 2048 + int'(amp * $cos(th - 2.0943951 * k))
                                  + $urandom_range(8) - 4;
                        if (code[k] < 0) code[k] = 0;
                        if (code[k] > 4095) code[k] = 4095;
                    end
                    send_sample(code[0], code[1], code[2]);
                end else begin
                    send_sample($urandom_range(4095), $urandom_range(4095),
                                $urandom_range(4095));
                end
            end
            drain();
        end

        if (errors == 0)
            $display("three_phase_srf_pll_spwm_unit regression: pass");
        else
            $display("three_phase_srf_pll_spwm_unit regression: fail");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/srfp_pkg.sv
hw/rtl/srfp_cos_rom.sv
hw/rtl/srfp_mul.sv
hw/rtl/three_phase_srf_pll_spwm_unit.sv
hw/rtl/srfp_checker.sv
sim/tb_top.sv
